// ===== rtl/cue_interval_lookup_assert.svh =====
// Assertion macros for the cue interval lookup block.
// Used by cil_ctrl, which checks its own control logic; needs clk and rst in scope.
`ifndef CUE_INTERVAL_LOOKUP_ASSERT_SVH
`define CUE_INTERVAL_LOOKUP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on the rising clock edge.
`define CIL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on the rising clock edge.
`define CIL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CIL_ASSERT_NOW(label, ante, cons, msg)
`define CIL_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/cil_pkg.sv =====
// Shared types and codes for the cue interval lookup block.
// No dependencies; used by cil_ctrl, cue_interval_lookup and the bench.
`default_nettype none

package cil_pkg;

  localparam int TIME_W  = 32;
  localparam int INDEX_W = 11;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    op_t                op;
    logic [TIME_W-1:0]  start_ms;
    logic [TIME_W-1:0]  duration_ms;
    logic [TIME_W-1:0]  query_ms;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic [INDEX_W-1:0] entry_index;
  } result_t;

  // Interval bounds as they are held in one memory word.
  typedef struct packed {
    logic [TIME_W-1:0] start_ms;
    logic [TIME_W-1:0] end_ms;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/cil_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module cil_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/cil_ctrl.sv =====
// Sequencer of the cue interval lookup: entry count, scan cursor, the
// forward scan over the entry memory and the result register.
// Depends on cil_pkg and cue_interval_lookup_assert.svh.
`default_nettype none
`include "cue_interval_lookup_assert.svh"

module cil_ctrl
  import cil_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire cmd_t                           cmd,
  output logic                                busy,
  output logic                                mem_we,
  output logic [$clog2(MAX_ENTRIES)-1:0]      mem_addr,
  input  wire entry_t                         mem_rdata,
  output logic                                done,
  output result_t                             result
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  ctrl_state_t       state;
  ctrl_state_t       state_next;
  logic [CW-1:0]     count;
  logic [AW-1:0]     cursor;
  logic [CW-1:0]     ptr;
  logic [AW-1:0]     cmp_addr;
  logic              pend;
  logic [TIME_W-1:0] query;

  logic accept;
  logic scan_hit;
  logic scan_end;
  logic full;

  assign accept   = start && !busy;
  assign full     = (count >= MAX_CNT);
  // The word for cmp_addr arrived this cycle; test it against the query.
  assign scan_hit = pend && (query >= mem_rdata.start_ms) && (query <= mem_rdata.end_ms);
  assign scan_end = !scan_hit && (ptr >= count);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && cmd.op == OP_QUERY) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_hit || scan_end) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b0;
    mem_we   = 1'b0;
    mem_addr = count[AW-1:0];
    unique case (state)
      S_IDLE: begin
        mem_we = accept && (cmd.op == OP_APPEND) && !full;
      end
      S_SCAN: begin
        busy     = 1'b1;
        mem_addr = ptr[AW-1:0];
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      cursor <= '0;
      pend   <= 1'b0;
      done   <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (accept) begin
        done <= (cmd.op != OP_QUERY);
        pend <= 1'b0;
        case (cmd.op)
          OP_APPEND: begin
            if (!full) begin
              count <= count + 1'b1;
            end
          end
          OP_CLEAR: begin
            count  <= '0;
            cursor <= '0;
          end
          default: begin
          end
        endcase
      end else if (state == S_SCAN) begin
        if (scan_hit) begin
          done   <= 1'b1;
          cursor <= cmp_addr;
        end else if (scan_end) begin
          done <= 1'b1;
        end else begin
          pend <= 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      result.status      <= STAT_OK;
      result.entry_index <= INDEX_W'(count);
      case (cmd.op)
        OP_APPEND: begin
          if (full) begin
            result.status <= STAT_FULL;
          end
        end
        OP_QUERY: begin
          query <= cmd.query_ms;
          ptr   <= CW'(cursor);
        end
        OP_CLEAR: begin
          result.entry_index <= '0;
        end
        default: begin
        end
      endcase
    end else if (state == S_SCAN) begin
      if (scan_hit) begin
        result.status      <= STAT_OK;
        result.entry_index <= INDEX_W'(cmp_addr);
      end else if (scan_end) begin
        result.status      <= STAT_MISS;
        result.entry_index <= INDEX_W'(count);
      end else begin
        cmp_addr <= ptr[AW-1:0];
        ptr      <= ptr + 1'b1;
      end
    end
  end

  `CIL_ASSERT_NOW(a_write_idle, mem_we, !busy, "entry write during a scan")
  `CIL_ASSERT_NEXT(a_scan_result, (state == S_SCAN) && (scan_hit || scan_end), done,
    "finished scan gave no result")
  `CIL_ASSERT_NOW(a_full_count, done && (result.status == STAT_FULL), count == MAX_CNT,
    "full status with room left in the table")
  `CIL_ASSERT_NOW(a_miss_cursor, done && (result.status == STAT_MISS), $stable(cursor),
    "cursor moved on a query miss")

endmodule

`default_nettype wire

// ===== rtl/cue_interval_lookup.sv =====
// Top level of the cue interval lookup: entry memory, end-time saturation
// and the sequencer. Depends on cil_pkg, cil_ram and cil_ctrl.
`default_nettype none

// Cue interval lookup. An item is taken at a rising edge where start is high
// and busy is low; every item gives exactly one result, shown on result for a
// single cycle while done is high. The receiver cannot stall, so it must take
// each result in that cycle. For append, clear and unused items the result
// appears in the cycle after the item and busy stays low, so such items can
// follow back to back. A query walks the entry memory one entry per cycle
// through a single read port, starting at the remembered cursor. A hit
// ends the walk at the first matching entry; a miss walks on to the end of
// the table. The result appears in the first cycle in which busy is low
// again. Since queries normally arrive with rising timestamps, the number
// of entries examined before a hit stays small.
// The entry memory needs no clearing after reset, since only entries below
// the entry count are ever compared with a query.
module cue_interval_lookup
  import cil_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire cmd_t    cmd,
  output logic         busy,
  output logic         done,
  output result_t      result
);

  localparam int AW = $clog2(MAX_ENTRIES);

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  entry_t        mem_wdata;
  entry_t        mem_rdata;
  logic [TIME_W:0] end_sum;

  // The end time is start plus duration, held at the largest value when the
  // sum runs past 32 bits.
  assign end_sum            = {1'b0, cmd.start_ms} + {1'b0, cmd.duration_ms};
  assign mem_wdata.start_ms = cmd.start_ms;
  assign mem_wdata.end_ms   = end_sum[TIME_W] ? '1 : end_sum[TIME_W-1:0];

  // Start and end of each entry share one memory word, so a scan step needs
  // one read.
  cil_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  cil_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_rdata (mem_rdata),
    .done      (done),
    .result    (result)
  );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for cue_interval_lookup: appends, queries, clears and unused codes.
// Needs cil_pkg and the block's RTL; a shadow table in the bench predicts every result.
`timescale 1ns / 100ps

module testbench;
  import cil_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  // The fourth op code has no meaning in the block; such an item only reports the count.
  localparam logic [1:0] OP_UNUSED_CODE = 2'd3;

  // Shadow copy of the cue table. Each accepted item updates it and queues the
  // result the block must give; results from the block are checked in order.
  class cue_table_shadow #(int DEPTH = 1024);
    logic [31:0] starts[DEPTH];
    logic [31:0] ends[DEPTH];
    int entry_count;
    int cursor;
    int failures;
    result_t awaited[$];

    function new();
      entry_count = 0;
      cursor = 0;
      failures = 0;
    endfunction

    function void take_item(cmd_t c);
      result_t r;
      logic [32:0] sum;
      bit found;
      r.status = STAT_OK;
      r.entry_index = entry_count[INDEX_W-1:0];
      found = 1'b0;
      case (c.op)
        OP_APPEND: begin
          if (entry_count >= DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            // The end time saturates rather than wrapping.
            sum = {1'b0, c.start_ms} + {1'b0, c.duration_ms};
            starts[entry_count] = c.start_ms;
            ends[entry_count] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            entry_count++;
          end
        end
        OP_QUERY: begin
          r.status = STAT_MISS;
          for (int x = cursor; x < entry_count && !found; x++) begin
            if (c.query_ms >= starts[x] && c.query_ms <= ends[x]) begin
              found = 1'b1;
              cursor = x;
              r.status = STAT_OK;
              r.entry_index = x[INDEX_W-1:0];
            end
          end
        end
        OP_CLEAR: begin
          entry_count = 0;
          cursor = 0;
          r.entry_index = '0;
        end
        default: begin
        end
      endcase
      awaited.push_back(r);
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: status %0d, entry_index %0d", got.status, got.entry_index);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        failures++;
      end
      if (got.entry_index !== want.entry_index) begin
        $error("entry_index: expected %0d, actual %0d", want.entry_index, got.entry_index);
        failures++;
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    busy;
  logic    done;
  result_t result;

  cue_table_shadow #(TABLE_DEPTH) shadow;
  int idle_pct = 0;
  int items_sent = 0;

  cue_interval_lookup #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Everything is sampled at the rising edge, so the values seen are the ones
  // from before the edge. A result showing now belongs to an item taken at an
  // earlier edge, so the order of the two checks does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        shadow.match_result(result);
      end
      if (start && !busy) begin
        shadow.take_item(cmd);
      end
    end
  end

  function automatic cmd_t make_item(input logic [1:0] code, input logic [31:0] s,
                                     input logic [31:0] d, input logic [31:0] qm);
    cmd_t c;
    c.op = op_t'(code);
    c.start_ms = s;
    c.duration_ms = d;
    c.query_ms = qm;
    return c;
  endfunction

  // Offers one item and returns just after the edge that takes it. Start may
  // drop for a random number of cycles first, as the current idle rate says.
  // While a query keeps busy high, start and cmd simply stay put.
  task automatic push_item(input cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (c.op != OP_UNUSED_CODE) begin
      items_sent++;
    end
  endtask

  // A realistic stretch of use: cues appended in time order, some overlapping,
  // then lookups with mostly rising timestamps, as frames would give them. Now
  // and then a lookup jumps back, which the forward-only cursor can miss.
  task automatic run_cue_session();
    logic [31:0] t;
    logic [31:0] q;
    int rounds;
    if ($urandom_range(9) == 0) begin
      t = 32'hFFFF_FFFF - $urandom_range(4000);
    end else begin
      t = $urandom;
    end
    q = t;
    rounds = $urandom_range(1, 3);
    if ($urandom_range(3) != 0) begin
      push_item(make_item(OP_CLEAR, $urandom, $urandom, $urandom));
    end
    repeat (rounds) begin
      repeat ($urandom_range(1, 12)) begin
        t = t + $urandom_range(0, 120);
        push_item(make_item(OP_APPEND, t, $urandom_range(0, 200), $urandom));
      end
      repeat ($urandom_range(1, 16)) begin
        if ($urandom_range(7) == 0) begin
          q = q - $urandom_range(0, 300);
        end else begin
          q = q + $urandom_range(0, 60);
        end
        push_item(make_item(OP_QUERY, $urandom, $urandom, q));
      end
    end
  endtask

  initial begin
    logic [31:0] t;
    logic [31:0] fill_last;
    int idle_plan[4];
    int ph;
    int k;
    int phase_end;

    shadow = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A lookup on the empty table finds the cursor already past the end.
    push_item(make_item(OP_QUERY, 32'h0, 32'h0, 32'h0));
    push_item(make_item(OP_APPEND, 32'h0, 32'h0, 32'h0));
    push_item(make_item(OP_APPEND, 32'd1000, 32'd10, 32'h0));
    // The sum runs past 32 bits, so this end saturates.
    push_item(make_item(OP_APPEND, 32'd100, 32'hFFFF_FFCD, 32'h0));
    push_item(make_item(OP_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
    // This sum lands exactly on the top value without overflowing.
    push_item(make_item(OP_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
    push_item(make_item(OP_QUERY, 32'h0, 32'h0, 32'h0));
    // Both ends of an interval are inclusive.
    push_item(make_item(OP_QUERY, 32'h0, 32'h0, 32'd1000));
    push_item(make_item(OP_QUERY, 32'h0, 32'h0, 32'd1010));
    push_item(make_item(OP_QUERY, 32'h0, 32'h0, 32'd1011));
    // Behind the cursor now, so this misses and the cursor stays.
    push_item(make_item(OP_QUERY, 32'h0, 32'h0, 32'd99));
    push_item(make_item(OP_QUERY, 32'h0, 32'h0, 32'hFFFF_FFFF));
    push_item(make_item(OP_UNUSED_CODE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    push_item(make_item(OP_APPEND, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF));
    push_item(make_item(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    push_item(make_item(OP_QUERY, 32'h0, 32'h0, 32'hFFFF_FFFF));
    push_item(make_item(OP_APPEND, 32'd500, 32'd10, 32'h0));
    push_item(make_item(OP_QUERY, 32'h0, 32'h0, 32'd499));
    push_item(make_item(OP_QUERY, 32'h0, 32'h0, 32'd510));
    push_item(make_item(OP_QUERY, 32'h0, 32'h0, 32'd511));
    push_item(make_item(OP_CLEAR, 32'h0, 32'h0, 32'h0));

    // Fill the table to the last slot, then push past it. The first lookup
    // sits below every cue and walks the whole table; the later ones rise
    // through it to the start of the top entry, and the last goes past it.
    idle_pct = 34;
    t = $urandom_range(1, 1000);
    repeat (TABLE_DEPTH) begin
      t = t + $urandom_range(1, 50);
      push_item(make_item(OP_APPEND, t, $urandom_range(0, 40), $urandom));
    end
    fill_last = t;
    repeat (3) push_item(make_item(OP_APPEND, $urandom, $urandom, $urandom));
    push_item(make_item(OP_QUERY, $urandom, $urandom, 32'h0));
    for (k = 1; k <= 12; k++) begin
      push_item(make_item(OP_QUERY, $urandom, $urandom, (fill_last / 12) * k));
    end
    push_item(make_item(OP_QUERY, $urandom, $urandom, fill_last));
    push_item(make_item(OP_QUERY, $urandom, $urandom, fill_last + 32'd100));
    push_item(make_item(OP_CLEAR, $urandom, $urandom, $urandom));

    // Random part in phases of sender idling. Results cannot be held off, so
    // the third phase, where the receiver would stall, runs without gaps.
    idle_plan = '{0, 55, 0, 34};
    for (ph = 0; ph < 4; ph++) begin
      idle_pct = idle_plan[ph];
      phase_end = items_sent + 125;
      while (items_sent < phase_end) begin
        if ($urandom_range(3) != 0) begin
          run_cue_session();
        end else begin
          // Noise: any op code, fields with every bit pattern.
          repeat ($urandom_range(1, 8)) begin
            push_item(make_item(2'($urandom_range(OP_APPEND, OP_UNUSED_CODE)),
                                $urandom, $urandom, $urandom));
          end
        end
      end
    end
    start <= 1'b0;

    while (shadow.outstanding() != 0) @(posedge clk);
    // Then wait on, to catch any stray result.
    repeat (8) @(posedge clk);
    if (shadow.outstanding() != 0) begin
      $error("%0d results never arrived", shadow.outstanding());
    end
    if (shadow.failures == 0 && shadow.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Ends the run as a mismatch if it hangs; the limit leaves room to spare even
  // if every query walked the whole table.
  initial begin
    #100_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cil_pkg.sv
rtl/cil_ram.sv
rtl/cil_ctrl.sv
rtl/cue_interval_lookup.sv
bench/testbench.sv
